[rtl/md5bsh_pkg.sv]
// shared types, constants and round tables for the md5 byte stream hasher
package md5bsh_pkg;

  // request kinds carried on the input tuser
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // initial chaining vector
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  // padding marker byte
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // working variables of one compression
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } quad_t;

  // additive constant of each step
  function automatic logic [31:0] step_const(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  // left rotate amount of each step
  function automatic logic [4:0] step_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by each step
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0:    g = i[3:0];
      2'd1:    g = 4'((i[3:0] << 2) + i[3:0] + 4'd1);
      2'd2:    g = 4'((i[3:0] << 1) + i[3:0] + 4'd5);
      2'd3:    g = 4'((i[3:0] << 3) - i[3:0]);
      default: g = i[3:0];
    endcase
    return g;
  endfunction

endpackage

[rtl/md5bsh_ram.sv]
// generic single write, single read port ram with registered read data
module md5bsh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[rtl/md5bsh_step.sv]
// one md5 compression step on the working variables
module md5bsh_step (
  input  md5bsh_pkg::quad_t cur,
  input  logic [31:0]       msg_word,
  input  logic [5:0]        step_idx,
  output md5bsh_pkg::quad_t nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [4:0]  rot;
  logic [63:0] dbl;

  // round function selected by step group
  always_comb begin
    case (step_idx[5:4])
      2'd0:    f = cur.d ^ (cur.b & (cur.c ^ cur.d));
      2'd1:    f = cur.c ^ (cur.d & (cur.b ^ cur.c));
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      2'd3:    f = cur.c ^ (cur.b | ~cur.d);
      default: f = 32'h0;
    endcase
  end

  // add, rotate and shift the variables
  always_comb begin
    sum    = f + cur.a + md5bsh_pkg::step_const(step_idx) + msg_word;
    rot    = md5bsh_pkg::step_rot(step_idx);
    dbl    = {sum, sum} << rot;
    nxt.a  = cur.d;
    nxt.d  = cur.c;
    nxt.c  = cur.b;
    nxt.b  = cur.b + dbl[63:32];
  end

endmodule

[rtl/md5_byte_stream_hasher_core.sv]
// md5 hasher over a byte stream: sequencer, byte packing and chaining state
//
// Input channel: each transfer carries one request. in_tuser = 0 adds the
// byte in in_tdata to the message; in_tuser = 1 finishes the message.
// Output channel: a finish produces four transfers, digest words a, b, c, d,
// with the word position on out_tuser and out_tlast on word d.
// The message block lives in a 16 x 32 ram; bytes are packed into a word
// register and written once per four bytes.
// Sequence: an add stores its byte; the add that completes a 64 byte block is
// followed by compression (64 steps, one per cycle, after a ram read lead
// step, then one chaining add); no byte is taken while it runs. A finish
// writes the closing word, fills the remaining words with zeros and the
// length, compresses, and fills and compresses a further block when the
// length does not fit the current block, then the four words follow.
// One request is handled at a time; in_tready is high only between requests.
// If the receiver stalls, the current digest word holds on out_tdata.
// Reset (rst_n low, synchronous) loads the initial chaining vector and
// clears the byte count; the block ram needs no clearing.
module md5_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FILL = 3'd1;
  localparam logic [2:0] ST_COMP = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  localparam logic [6:0] LAST_STEP = 7'd64;

  logic [2:0]        state_r, state_nxt;
  logic [63:0]       cnt_r, cnt_nxt;
  logic [23:0]       part_r, part_nxt;
  logic [3:0]        fa_r, fa_nxt;
  logic              pad2_r, pad2_nxt;
  logic              final_r, final_nxt;
  logic [6:0]        step_r, step_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic [31:0]       chain_r [4];
  logic [31:0]       chain_nxt [4];
  md5bsh_pkg::quad_t work_r, work_nxt;
  md5bsh_pkg::quad_t step_out;

  logic        in_xfer;
  logic        out_xfer;
  logic [5:0]  used;
  logic [1:0]  pos;
  logic [3:0]  wi;
  logic [31:0] fin_word;
  logic [63:0] bits;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [5:0]  cur_step;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;
  assign used     = cnt_r[5:0];
  assign pos      = used[1:0];
  assign wi       = used[5:2];
  assign bits     = {cnt_r[60:0], 3'b000};
  assign cur_step = 6'(step_r - 7'd1);

  // handshake outputs
  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = chain_r[idx_r];
  assign out_tuser  = idx_r;
  assign out_tlast  = (idx_r == 2'd3);

  // closing word: earlier bytes, the pad marker, then zeros
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      if (2'(k) < pos) begin
        fin_word[k*8 +: 8] = (k < 3) ? part_r[(k%3)*8 +: 8] : 8'h00;
      end else if (2'(k) == pos) begin
        fin_word[k*8 +: 8] = md5bsh_pkg::PAD_BYTE;
      end else begin
        fin_word[k*8 +: 8] = 8'h00;
      end
    end
  end

  // block ram write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wi;
    ram_wdata = {in_tdata, part_r};
    if (state_r == ST_IDLE && in_xfer) begin
      if (in_tuser == md5bsh_pkg::REQ_FINISH) begin
        ram_we    = 1'b1;
        ram_wdata = fin_word;
      end else begin
        ram_we = (pos == 2'd3);
      end
    end else if (state_r == ST_FILL) begin
      ram_we    = 1'b1;
      ram_waddr = fa_r;
      if (!pad2_r && fa_r == 4'd14) begin
        ram_wdata = bits[31:0];
      end else if (!pad2_r && fa_r == 4'd15) begin
        ram_wdata = bits[63:32];
      end else begin
        ram_wdata = 32'h0;
      end
    end
  end

  // address of the message word for the next step, read through the registered ram port
  assign ram_raddr = md5bsh_pkg::msg_index(step_r[5:0]);

  md5bsh_ram #(
    .WIDTH (32),
    .DEPTH (16)
  ) u_block_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  md5bsh_step u_step (
    .cur      (work_r),
    .msg_word (ram_rdata),
    .step_idx (cur_step),
    .nxt      (step_out)
  );

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    part_nxt  = part_r;
    fa_nxt    = fa_r;
    pad2_nxt  = pad2_r;
    final_nxt = final_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    work_nxt  = work_r;
    for (int i = 0; i < 4; i++) begin
      chain_nxt[i] = chain_r[i];
    end
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          step_nxt = 7'd0;
          if (in_tuser == md5bsh_pkg::REQ_FINISH) begin
            final_nxt = 1'b1;
            pad2_nxt  = (wi >= 4'd14);
            fa_nxt    = 4'(wi + 4'd1);
            state_nxt = (wi == 4'd15) ? ST_COMP : ST_FILL;
          end else begin
            cnt_nxt = cnt_r + 64'd1;
            if (pos != 2'd3) begin
              part_nxt[pos*8 +: 8] = in_tdata;
            end
            if (used == 6'd63) begin
              state_nxt = ST_COMP;
            end
          end
        end
      end
      ST_FILL: begin
        fa_nxt = 4'(fa_r + 4'd1);
        if (fa_r == 4'd15) begin
          step_nxt  = 7'd0;
          state_nxt = ST_COMP;
        end
      end
      ST_COMP: begin
        step_nxt = step_r + 7'd1;
        if (step_r == 7'd0) begin
          work_nxt = '{a: chain_r[0], b: chain_r[1], c: chain_r[2], d: chain_r[3]};
        end else begin
          work_nxt = step_out;
        end
        if (step_r == LAST_STEP) begin
          state_nxt = ST_ADD;
        end
      end
      ST_ADD: begin
        chain_nxt[0] = chain_r[0] + work_r.a;
        chain_nxt[1] = chain_r[1] + work_r.b;
        chain_nxt[2] = chain_r[2] + work_r.c;
        chain_nxt[3] = chain_r[3] + work_r.d;
        if (pad2_r) begin
          pad2_nxt  = 1'b0;
          fa_nxt    = 4'd0;
          state_nxt = ST_FILL;
        end else if (final_r) begin
          idx_nxt   = 2'd0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_OUT: begin
        if (out_xfer) begin
          idx_nxt = 2'(idx_r + 2'd1);
          if (idx_r == 2'd3) begin
            chain_nxt[0] = md5bsh_pkg::IV_A;
            chain_nxt[1] = md5bsh_pkg::IV_B;
            chain_nxt[2] = md5bsh_pkg::IV_C;
            chain_nxt[3] = md5bsh_pkg::IV_D;
            cnt_nxt      = 64'd0;
            final_nxt    = 1'b0;
            state_nxt    = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and chaining registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      cnt_r      <= 64'd0;
      pad2_r     <= 1'b0;
      final_r    <= 1'b0;
      step_r     <= 7'd0;
      idx_r      <= 2'd0;
      chain_r[0] <= md5bsh_pkg::IV_A;
      chain_r[1] <= md5bsh_pkg::IV_B;
      chain_r[2] <= md5bsh_pkg::IV_C;
      chain_r[3] <= md5bsh_pkg::IV_D;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pad2_r  <= pad2_nxt;
      final_r <= final_nxt;
      step_r  <= step_nxt;
      idx_r   <= idx_nxt;
      for (int i = 0; i < 4; i++) begin
        chain_r[i] <= chain_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    part_r <= part_nxt;
    fa_r   <= fa_nxt;
    work_r <= work_nxt;
  end

`ifndef NO_ASSERTIONS
  // never take a request while a digest is being delivered
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while digest pending");

  // the block ram is not written during compression
  a_no_write_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) |-> !ram_we)
    else $error("block write during compression");

  // step counter stays within one compression
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COMP) |-> (step_r <= LAST_STEP))
    else $error("step counter overran");

  // a completed digest leaves a fresh message state
  a_fresh_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_tlast) |=> (cnt_r == 64'd0 && chain_r[0] == md5bsh_pkg::IV_A
                                 && state_r == ST_IDLE))
    else $error("state not reinitialized after digest");

  // an add that fills the block starts compression
  a_full_block_compress: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_tuser == md5bsh_pkg::REQ_ADD && used == 6'd63) |=>
    (state_r == ST_COMP && step_r == 7'd0))
    else $error("full block not compressed");
`endif

endmodule
